// ----- rtl/reb_pkg.sv -----
`timescale 1ns / 1ps

package reb_pkg;

  localparam int CfgBits           = 16;
  localparam int CfgIdxBits        = 1;
  localparam int TimeBitsDefault   = 32;
  localparam int SumBitsDefault    = 16;
  localparam int EventBits         = 3;
  localparam int StepBits          = 5;

  localparam logic [CfgBits-1:0] NoiseFloorReset = 16'd50;
  localparam logic [CfgBits-1:0] LongPressReset  = 16'd500;

  typedef enum logic [EventBits-1:0] {
    EV_NONE  = 3'd0,
    EV_INC   = 3'd1,
    EV_DEC   = 3'd2,
    EV_SHORT = 3'd3,
    EV_LONG  = 3'd4
  } reb_event_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_PULL   = 1'b1
  } reb_op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_NOISE_FLOOR = 1'b0,
    CFG_LONG_PRESS  = 1'b1
  } reb_cfg_e;

  // quadrature step per transition history, impossible transitions give 14
  function automatic logic signed [StepBits-1:0] reb_step(input logic [3:0] hist);
    logic signed [StepBits-1:0] s;
    unique case (hist)
      4'd0, 4'd5, 4'd10, 4'd15:   s = 5'sd0;
      4'd2, 4'd4, 4'd11, 4'd13:   s = 5'sd1;
      4'd1, 4'd7, 4'd8, 4'd14:    s = -5'sd1;
      default:                    s = 5'sd14;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/reb_turn.sv -----
`timescale 1ns / 1ps

module reb_turn #(
  parameter int SUM_BITS = reb_pkg::SumBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               phase_a_i,
  input  logic               phase_b_i,
  output reb_pkg::reb_event_e event_o
);
  import reb_pkg::*;

  localparam logic [SUM_BITS-1:0] PlusFour  = SUM_BITS'(4);
  localparam logic [SUM_BITS-1:0] MinusFour = ~PlusFour + SUM_BITS'(1);

  logic [3:0]            hist_q, hist_d;
  logic [SUM_BITS-1:0]   sum_q, sum_d;
  logic signed [StepBits-1:0] step;
  logic [SUM_BITS-1:0]   step_ext;
  logic [SUM_BITS-1:0]   sum_add;

  always_comb begin
    hist_d   = {hist_q[1:0], phase_a_i, phase_b_i};
    step     = reb_step(hist_d);
    step_ext = {{(SUM_BITS-StepBits){step[StepBits-1]}}, step};
    sum_add  = sum_q + step_ext;
    sum_d    = sum_add;
    event_o  = EV_NONE;
    if (sum_add[1:0] == 2'b00) begin
      sum_d = '0;
      if (sum_add == PlusFour) begin
        event_o = EV_INC;
      end else if (sum_add == MinusFour) begin
        event_o = EV_DEC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      sum_q  <= '0;
    end else if (en_i) begin
      hist_q <= hist_d;
      sum_q  <= sum_d;
    end
  end

endmodule

// ----- rtl/reb_button.sv -----
`timescale 1ns / 1ps

module reb_button #(
  parameter int TIME_BITS = reb_pkg::TimeBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        button_level_i,
  input  logic [TIME_BITS-1:0]        now_ms_i,
  input  logic [reb_pkg::CfgBits-1:0] noise_floor_i,
  input  logic [reb_pkg::CfgBits-1:0] long_press_i,
  output reb_pkg::reb_event_e         event_o
);
  import reb_pkg::*;

  logic                 held_q, held_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] held_time;

  always_comb begin
    held_d    = held_q;
    start_d   = start_q;
    held_time = now_ms_i - start_q;
    event_o   = EV_NONE;
    if (!button_level_i && !held_q) begin
      held_d  = 1'b1;
      start_d = now_ms_i;
    end else if (button_level_i && held_q) begin
      held_d = 1'b0;
      if (held_time > TIME_BITS'(noise_floor_i)) begin
        event_o = (held_time > TIME_BITS'(long_press_i)) ? EV_LONG : EV_SHORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      start_q <= '0;
    end else if (en_i) begin
      held_q  <= held_d;
      start_q <= start_d;
    end
  end

endmodule

// ----- rtl/rotary_encoder_button_event_decoder.sv -----
`timescale 1ns / 1ps

// channel  direction  signals
// in       sink       in_valid_i, in_stall_o, opcode_i, phase_a_i, phase_b_i,
//                     button_level_i, now_ms_i
// out      source     out_valid_o, out_stall_i, cached_event_o
// cfg      sink       cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle while no held result stalls the input; the result passes
// through the input register, the table add and compares, and the result register
// reset clears history, sum, button state, event cache and restores config defaults
// out stall holds the result register and then the input register; in_stall_o
// rises only while an item waits in the input register behind a held result

module rotary_encoder_button_event_decoder #(
  parameter int TIME_BITS = reb_pkg::TimeBitsDefault,
  parameter int SUM_BITS  = reb_pkg::SumBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic                           phase_a_i,
  input  logic                           phase_b_i,
  input  logic                           button_level_i,
  input  logic [TIME_BITS-1:0]           now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [reb_pkg::EventBits-1:0]  cached_event_o,
  input  logic                           cfg_we_i,
  input  logic [reb_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [reb_pkg::CfgBits-1:0]    cfg_wdata_i
);
  import reb_pkg::*;

  logic                 in_valid_q;
  reb_op_e              op_q;
  logic                 phase_a_q, phase_b_q, button_q;
  logic [TIME_BITS-1:0] now_q;

  logic                 out_valid_q;
  reb_event_e           result_q, result_d;
  reb_event_e           cache_q, cache_d;

  logic [CfgBits-1:0]   noise_floor_q;
  logic [CfgBits-1:0]   long_press_q;

  logic                 out_free;
  logic                 advance;
  logic                 in_accept;
  logic                 sample_en;
  reb_event_e           bev, tev;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign sample_en  = advance && (op_q == OP_SAMPLE);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_floor_q <= NoiseFloorReset;
      long_press_q  <= LongPressReset;
    end else if (cfg_we_i) begin
      unique case (reb_cfg_e'(cfg_idx_i))
        CFG_NOISE_FLOOR: noise_floor_q <= cfg_wdata_i;
        CFG_LONG_PRESS:  long_press_q  <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= reb_op_e'(opcode_i);
      phase_a_q <= phase_a_i;
      phase_b_q <= phase_b_i;
      button_q  <= button_level_i;
      now_q     <= now_ms_i;
    end
  end

  reb_button #(
    .TIME_BITS(TIME_BITS)
  ) u_button (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (sample_en),
    .button_level_i(button_q),
    .now_ms_i      (now_q),
    .noise_floor_i (noise_floor_q),
    .long_press_i  (long_press_q),
    .event_o       (bev)
  );

  reb_turn #(
    .SUM_BITS(SUM_BITS)
  ) u_turn (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (sample_en),
    .phase_a_i(phase_a_q),
    .phase_b_i(phase_b_q),
    .event_o  (tev)
  );

  // button event wins over a turn event
  always_comb begin
    cache_d  = cache_q;
    result_d = cache_q;
    if (op_q == OP_PULL) begin
      cache_d = EV_NONE;
    end else begin
      if (bev != EV_NONE) begin
        cache_d = bev;
      end else if (tev != EV_NONE) begin
        cache_d = tev;
      end
      result_d = cache_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_q     <= EV_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        cache_q <= cache_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cached_event_o = result_q;

  a_pull_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (op_q == OP_PULL) |=> cache_q == EV_NONE)
    else $error("cache not cleared after pull");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item produced no result");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held item");

  a_sample_result_is_cache: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_en |=> result_q == cache_q)
    else $error("sample result differs from cache");

endmodule

// ----- dv/rotary_encoder_button_event_decoder_test.sv -----
`timescale 1ns / 1ps

module rotary_encoder_button_event_decoder_test;
  import reb_pkg::*;

  localparam int TimeBits = TimeBitsDefault;
  localparam int SumBits = SumBitsDefault;
  localparam int NumSettings = 6;
  localparam int ItemsPerSetting = 220;
  localparam int LongHoldCycles = 150;
  localparam int LongHoldAfter = 500;
  localparam int WatchdogLimit = 3000;
  localparam logic [SumBits-1:0] SumMinusFour = SumBits'(-4);

  typedef struct {
    reb_op_e             op;
    logic [1:0]          ab;
    logic                btn;
    logic [TimeBits-1:0] now;
  } enc_sample_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  opcode_i = 1'b0;
  logic                  phase_a_i = 1'b0;
  logic                  phase_b_i = 1'b0;
  logic                  button_level_i = 1'b1;
  logic [TimeBits-1:0]   now_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [EventBits-1:0]  cached_event_o;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgBits-1:0]    cfg_wdata_i = '0;

  rotary_encoder_button_event_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .phase_a_i      (phase_a_i),
    .phase_b_i      (phase_b_i),
    .button_level_i (button_level_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cached_event_o (cached_event_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder state as the testbench sees it
  logic [CfgBits-1:0]  noise_floor_ms = NoiseFloorReset;
  logic [CfgBits-1:0]  long_press_ms = LongPressReset;
  logic [3:0]          quad_hist = '0;
  logic [SumBits-1:0]  step_acc = '0;
  logic                btn_down = 1'b0;
  logic [TimeBits-1:0] press_ms = '0;
  reb_event_e          event_reg = EV_NONE;

  enc_sample_t sample_queue[$];
  reb_event_e  event_queue[$];
  reb_event_e  exp_ev;

  logic [CfgBits-1:0] floor_set [NumSettings] = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd50};
  logic [CfgBits-1:0] long_set [NumSettings] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd500};

  int err_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int idle_cycles = 0;

  logic [1:0]          gen_ab = 2'b00;
  logic                gen_btn = 1'b1;
  logic [TimeBits-1:0] gen_ms = '0;
  int                  gen_count = 0;

  function automatic reb_event_e decode_item(reb_op_e op, logic a, logic b, logic btn,
                                             logic [TimeBits-1:0] now);
    reb_event_e          ev;
    reb_event_e          btn_ev;
    reb_event_e          turn_ev;
    logic [TimeBits-1:0] held;
    logic [SumBits-1:0]  step;
    if (op == OP_PULL) begin
      ev = event_reg;
      event_reg = EV_NONE;
      return ev;
    end
    btn_ev = EV_NONE;
    if (!btn && !btn_down) begin
      press_ms = now;
      btn_down = 1'b1;
    end else if (btn && btn_down) begin
      btn_down = 1'b0;
      held = now - press_ms;
      if (held > TimeBits'(noise_floor_ms)) begin
        btn_ev = (held > TimeBits'(long_press_ms)) ? EV_LONG : EV_SHORT;
      end
    end
    quad_hist = {quad_hist[1:0], a, b};
    case (quad_hist)
      4'd2, 4'd4, 4'd11, 4'd13: step = SumBits'(1);
      4'd1, 4'd7, 4'd8, 4'd14:  step = '1;
      4'd3, 4'd6, 4'd9, 4'd12:  step = SumBits'(14);
      default:                  step = '0;
    endcase
    step_acc = step_acc + step;
    turn_ev = EV_NONE;
    if (step_acc[1:0] == 2'b00) begin
      if (step_acc == SumBits'(4)) begin
        turn_ev = EV_INC;
      end else if (step_acc == SumMinusFour) begin
        turn_ev = EV_DEC;
      end
      step_acc = '0;
    end
    if (btn_ev != EV_NONE) begin
      event_reg = btn_ev;
    end else if (turn_ev != EV_NONE) begin
      event_reg = turn_ev;
    end
    return event_reg;
  endfunction

  task automatic add_sample(input logic [1:0] ab, input logic btn, input logic [TimeBits-1:0] now);
    sample_queue.push_back('{OP_SAMPLE, ab, btn, now});
    gen_ab = ab;
    gen_btn = btn;
    gen_count++;
  endtask

  task automatic add_pull();
    sample_queue.push_back('{OP_PULL, 2'($urandom), 1'($urandom), TimeBits'($urandom)});
    gen_count++;
  endtask

  task automatic queue_random(input int n);
    int                  stop;
    int                  steps;
    logic [1:0]          pos;
    logic [1:0]          dir;
    logic [TimeBits-1:0] press_at;
    logic [TimeBits-1:0] held;
    stop = gen_count + n;
    while (gen_count < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          dir = $urandom_range(0, 1) ? 2'd1 : 2'd3;
          pos = {gen_ab[0], gen_ab[1] ^ gen_ab[0]};
          steps = $urandom_range(1, 6);
          repeat (steps) begin
            case ($urandom_range(0, 9))
              0: ;
              1: pos = pos - dir;
              default: pos = pos + dir;
            endcase
            gen_ms = gen_ms + TimeBits'($urandom_range(0, 3));
            add_sample({pos[1] ^ pos[0], pos[1]}, gen_btn, gen_ms);
          end
        end
        4, 5: begin
          if ($urandom_range(0, 7) == 0) begin
            gen_ms = '1 - TimeBits'($urandom_range(0, 300));
          end
          press_at = gen_ms;
          add_sample(gen_ab, 1'b0, press_at);
          repeat ($urandom_range(0, 3)) begin
            add_sample(gen_ab, 1'b0, press_at + TimeBits'($urandom_range(0, 40)));
          end
          case ($urandom_range(0, 8))
            0: held = TimeBits'(noise_floor_ms);
            1: held = TimeBits'(noise_floor_ms) + TimeBits'(1);
            2: held = TimeBits'(long_press_ms);
            3: held = TimeBits'(long_press_ms) + TimeBits'(1);
            4: held = TimeBits'($urandom_range(0, 1000));
            5: held = TimeBits'($urandom_range(0, 200000));
            6: held = '1 - TimeBits'($urandom_range(0, 3));
            7: held = TimeBits'($urandom);
            default: held = '0;
          endcase
          gen_ms = press_at + held;
          // release may also complete a detent
          pos = {gen_ab[0], gen_ab[1] ^ gen_ab[0]};
          if ($urandom_range(0, 1)) begin
            pos = pos + 2'd1;
          end
          add_sample({pos[1] ^ pos[0], pos[1]}, 1'b1, gen_ms);
        end
        6, 8: add_pull();
        7: begin
          gen_ms = TimeBits'($urandom);
          add_sample(2'($urandom), 1'($urandom), gen_ms);
        end
        default: add_sample(gen_ab, gen_btn, gen_ms + TimeBits'($urandom_range(0, 5)));
      endcase
    end
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid_i || event_queue.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reb_cfg_e idx, input logic [CfgBits-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NOISE_FLOOR) begin
      noise_floor_ms = val;
    end else begin
      long_press_ms = val;
    end
  endtask

  // sender: bursts of random length with random gaps
  int          burst_left = 1;
  int          gap_left = 0;
  enc_sample_t drive_item;
  logic        send_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      send_next = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        event_queue.push_back(decode_item(reb_op_e'(opcode_i), phase_a_i, phase_b_i,
                                          button_level_i, now_ms_i));
        items_sent++;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = $urandom_range(1, 40);
        end
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_queue.size() > 0) begin
          drive_item = sample_queue.pop_front();
          send_next = 1'b1;
          opcode_i <= drive_item.op;
          phase_a_i <= drive_item.ab[1];
          phase_b_i <= drive_item.ab[0];
          button_level_i <= drive_item.btn;
          now_ms_i <= drive_item.now;
        end
        in_valid_i <= send_next;
      end
    end
  end

  // receiver: random stall patterns of random length, one long hold-off
  int   stall_mode = 0;
  int   pattern_left = 0;
  int   hold_left = 0;
  int   taken = 0;
  logic long_hold_done = 1'b0;
  logic stall_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        taken++;
      end
      if (!long_hold_done && taken >= LongHoldAfter) begin
        hold_left = LongHoldCycles;
        long_hold_done = 1'b1;
      end
      if (pattern_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(8, 64);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 3) == 0);
          2: stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = !out_stall_i;
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (event_queue.size() == 0) begin
        if (err_count < 20) begin
          $display("%0t: unexpected transaction, expected none actual %0d", $time,
                   cached_event_o);
        end
        err_count++;
      end else begin
        exp_ev = event_queue.pop_front();
        if (cached_event_o !== exp_ev) begin
          if (err_count < 20) begin
            $display("%0t: cached_event mismatch, expected %0d actual %0d", $time, exp_ev,
                     cached_event_o);
          end
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("[rotary_encoder_button_event_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    floor_set[4] = CfgBits'($urandom);
    long_set[4] = CfgBits'($urandom);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_pull();
    // one detent each way
    add_sample(2'b10, 1'b1, 32'h0000_0000);
    add_sample(2'b11, 1'b1, 32'd1);
    add_sample(2'b01, 1'b1, 32'd2);
    add_sample(2'b00, 1'b1, 32'd3);
    add_sample(2'b01, 1'b1, 32'd4);
    add_sample(2'b11, 1'b1, 32'd5);
    add_sample(2'b10, 1'b1, 32'd6);
    add_sample(2'b00, 1'b1, 32'd7);
    add_pull();
    add_pull();
    // impossible jumps clear the sum without an event
    add_sample(2'b11, 1'b1, 32'd8);
    add_sample(2'b00, 1'b1, 32'd9);
    // held exactly at the noise floor, just above it, exactly at the long threshold
    add_sample(2'b00, 1'b0, 32'd1000);
    add_sample(2'b00, 1'b1, 32'd1050);
    add_sample(2'b00, 1'b0, 32'd2000);
    add_sample(2'b00, 1'b1, 32'd2051);
    add_sample(2'b00, 1'b0, 32'd3000);
    add_sample(2'b00, 1'b1, 32'd3500);
    // release and detent in the same transaction, button wins
    add_sample(2'b10, 1'b0, 32'd5000);
    add_sample(2'b11, 1'b0, 32'd5001);
    add_sample(2'b01, 1'b0, 32'd5002);
    add_sample(2'b00, 1'b1, 32'd5100);
    // timestamp wraps during a long press
    add_sample(2'b00, 1'b0, 32'hFFFF_FFFF);
    add_sample(2'b00, 1'b1, 32'h0000_01F5);
    add_pull();
    gen_ms = 32'h0000_01F5;
    queue_random(ItemsPerSetting / 4);

    for (int p = 0; p < NumSettings; p++) begin
      wait_drained();
      write_reg(CFG_NOISE_FLOOR, floor_set[p]);
      write_reg(CFG_LONG_PRESS, long_set[p]);
      @(negedge clk_i);
      queue_random(ItemsPerSetting);
    end
    wait_drained();

    $display("run covered %0d input transactions and %0d checked results over %0d settings",
             items_sent, results_checked, NumSettings + 1);
    $display("including detents both ways, all press classes, wrap and a %0d-cycle stall",
             LongHoldCycles);
    if (err_count == 0) begin
      $display("[rotary_encoder_button_event_decoder] OK");
    end else begin
      $display("[rotary_encoder_button_event_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/reb_pkg.sv
rtl/reb_turn.sv
rtl/reb_button.sv
rtl/rotary_encoder_button_event_decoder.sv
dv/rotary_encoder_button_event_decoder_test.sv
